>>> hw/rtl/sel_pkg.sv
// Shared types, mode and kind codes, and byte classification for the expression lexer.
package sel_pkg;

	localparam logic [2:0] M_IDLE  = 3'd0;
	localparam logic [2:0] M_NUM   = 3'd1;
	localparam logic [2:0] M_IDENT = 3'd2;
	localparam logic [2:0] M_DQ    = 3'd3;
	localparam logic [2:0] M_SQ    = 3'd4;
	localparam logic [2:0] M_SKIP  = 3'd5;

	localparam logic [1:0] K_IDENT = 2'd0;
	localparam logic [1:0] K_OP    = 2'd1;
	localparam logic [1:0] K_STR   = 2'd2;
	localparam logic [1:0] K_NUM   = 2'd3;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] char_in;
		logic       char_valid;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		logic [7:0] lexeme_byte;
		logic       byte_present;
		logic [1:0] token_kind;
		logic       token_end;
		logic       unrecognized;
		logic       run_last;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
		logic [2:0] mode;
	} take_t;

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alp(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic is_spc(input logic [7:0] c);
		return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alp(c) || is_dig(c) || (c == "_");
	endfunction

	function automatic logic is_numc(input logic [7:0] c);
		return is_dig(c) || (c == ".");
	endfunction

	function automatic logic is_op1(input logic [7:0] c);
		return (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "%") ||
			(c == "=") || (c == "<") || (c == ">") || (c == "!");
	endfunction

	function automatic logic is_op2(input logic [7:0] a, input logic [7:0] b);
		return ((b == "=") && ((a == "=") || (a == "<") || (a == ">"))) ||
			((a == "&") && (b == "&")) || ((a == "|") && (b == "|"));
	endfunction

	function automatic res_t mk_res(input logic [7:0] b, input logic pres,
			input logic [1:0] kind, input logic fin, input logic unrec);
		res_t r;
		r.lexeme_byte  = b;
		r.byte_present = pres;
		r.token_kind   = kind;
		r.token_end    = fin;
		r.unrecognized = unrec;
		r.run_last     = 1'b0;
		return r;
	endfunction

	// classify held byte h in the given mode; has_la says whether lookahead la exists
	function automatic take_t lex_take(input logic [2:0] mode, input logic [7:0] h,
			input logic has_la, input logic [7:0] la);
		take_t t;
		logic fin;
		logic [7:0] q;
		t = '0;
		t.mode = M_IDLE;
		fin = 1'b0;
		q = "\"";
		case (mode)
			M_SKIP: begin
				t.mode = M_IDLE;
			end
			M_NUM: begin
				fin = !(has_la && is_numc(la));
				t.cnt = 2'd1;
				t.r0 = mk_res(h, 1'b1, K_NUM, fin, 1'b0);
				t.mode = fin ? M_IDLE : M_NUM;
			end
			M_IDENT: begin
				fin = !(has_la && is_word(la));
				t.cnt = 2'd1;
				t.r0 = mk_res(h, 1'b1, K_IDENT, fin, 1'b0);
				t.mode = fin ? M_IDLE : M_IDENT;
			end
			M_DQ, M_SQ: begin
				q = (mode == M_DQ) ? "\"" : "'";
				fin = !has_la || (la == q);
				t.cnt = 2'd1;
				t.r0 = mk_res(h, 1'b1, K_STR, fin, 1'b0);
				t.mode = fin ? (has_la ? M_SKIP : M_IDLE) : mode;
			end
			default: begin
				if (is_spc(h)) begin
					t.mode = M_IDLE;
				end else if (is_dig(h) || ((h == ".") && has_la && is_dig(la))) begin
					fin = !(has_la && is_numc(la));
					t.cnt = 2'd1;
					t.r0 = mk_res(h, 1'b1, K_NUM, fin, 1'b0);
					t.mode = fin ? M_IDLE : M_NUM;
				end else if ((h == "\"") || (h == "'")) begin
					if (!has_la || (la == h)) begin
						t.cnt = 2'd1;
						t.r0 = mk_res(8'h00, 1'b0, K_STR, 1'b1, 1'b0);
						t.mode = has_la ? M_SKIP : M_IDLE;
					end else begin
						t.mode = (h == "\"") ? M_DQ : M_SQ;
					end
				end else if (is_alp(h) || (h == "_")) begin
					fin = !(has_la && is_word(la));
					t.cnt = 2'd1;
					t.r0 = mk_res(h, 1'b1, K_IDENT, fin, 1'b0);
					t.mode = fin ? M_IDLE : M_IDENT;
				end else if (has_la && is_op2(h, la)) begin
					t.cnt = 2'd2;
					t.r0 = mk_res(h, 1'b1, K_OP, 1'b0, 1'b0);
					t.r1 = mk_res(la, 1'b1, K_OP, 1'b1, 1'b0);
					t.mode = M_SKIP;
				end else if (is_op1(h)) begin
					t.cnt = 2'd1;
					t.r0 = mk_res(h, 1'b1, K_OP, 1'b1, 1'b0);
				end else begin
					t.cnt = 2'd1;
					t.r0 = mk_res(h, 1'b0, K_IDENT, 1'b0, 1'b1);
				end
			end
		endcase
		return t;
	endfunction

endpackage

>>> hw/rtl/sel_ifs.sv
// Request channel interfaces for text bytes in and lexeme results out.
interface sel_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       char_valid;
	logic       end_of_text;

	modport source(output valid, char_in, char_valid, end_of_text, input ready);
	modport sink(input valid, char_in, char_valid, end_of_text, output ready);
endinterface

interface sel_token_if;
	logic       valid;
	logic       ready;
	logic [7:0] lexeme_byte;
	logic       byte_present;
	logic [1:0] token_kind;
	logic       token_end;
	logic       unrecognized;
	logic       run_last;

	modport source(output valid, lexeme_byte, byte_present, token_kind, token_end,
		unrecognized, run_last, input ready);
	modport sink(input valid, lexeme_byte, byte_present, token_kind, token_end,
		unrecognized, run_last, output ready);
endinterface

>>> hw/rtl/sel_lex_core.sv
// Lexer state registers and per-request classification producing up to two results.
module sel_lex_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  sel_pkg::item_t item,
	output logic [1:0]    res_cnt,
	output sel_pkg::res_t res_lo,
	output sel_pkg::res_t res_hi
);
	import sel_pkg::*;

	logic [2:0] mode_q;
	logic [7:0] held_q;
	logic       held_valid_q;

	take_t      t1;
	take_t      t2;
	logic       do1;
	logic       do2;
	logic [2:0] mode_a;
	logic [7:0] held_a;
	logic       valid_a;
	logic [1:0] c1;
	logic [1:0] c2;

	always_comb begin
		t1 = lex_take(mode_q, held_q, 1'b1, item.char_in);
		do1 = item.char_valid && held_valid_q;
		mode_a = do1 ? t1.mode : mode_q;
		held_a = item.char_valid ? item.char_in : held_q;
		valid_a = item.char_valid || held_valid_q;
		t2 = lex_take(mode_a, held_a, 1'b0, 8'h00);
		do2 = item.end_of_text && valid_a;
		c1 = do1 ? t1.cnt : 2'd0;
		c2 = do2 ? t2.cnt : 2'd0;
		res_cnt = c1 + c2;
		res_lo = (c1 != 2'd0) ? t1.r0 : t2.r0;
		res_hi = (c1 == 2'd2) ? t1.r1 : t2.r0;
		res_lo.run_last = (res_cnt == 2'd1);
		res_hi.run_last = (res_cnt == 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_IDLE;
			held_q       <= 8'h00;
			held_valid_q <= 1'b0;
		end else if (step) begin
			if (item.end_of_text) begin
				mode_q       <= M_IDLE;
				held_q       <= 8'h00;
				held_valid_q <= 1'b0;
			end else begin
				mode_q       <= mode_a;
				held_q       <= held_a;
				held_valid_q <= valid_a;
			end
		end
	end

endmodule

>>> hw/rtl/sel_res_fifo.sv
// Result queue taking up to two results per cycle and sending one per request.
module sel_res_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    push_cnt,
	input  sel_pkg::res_t push_lo,
	input  sel_pkg::res_t push_hi,
	output logic          room,
	sel_token_if.source   token
);
	import sel_pkg::*;

	localparam logic [QCNT_W-1:0] ROOM_MAX = QCNT_W'(QDEPTH - 2);
	localparam logic [QCNT_W-1:0] CNT_MAX  = QCNT_W'(QDEPTH);

	res_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] head_q;
	logic [QPTR_W-1:0] tail_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;
	res_t              head_r;

	assign room   = (count_q <= ROOM_MAX);
	assign pop    = token.valid && token.ready;
	assign head_r = mem_q[head_q];

	assign token.valid        = (count_q != '0);
	assign token.lexeme_byte  = head_r.lexeme_byte;
	assign token.byte_present = head_r.byte_present;
	assign token.token_kind   = head_r.token_kind;
	assign token.token_end    = head_r.token_end;
	assign token.unrecognized = head_r.unrecognized;
	assign token.run_last     = head_r.run_last;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[tail_q] <= push_lo;
		end
		if (push_cnt == 2'd2) begin
			mem_q[tail_q + QPTR_W'(1)] <= push_hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q  <= head_q + QPTR_W'(pop);
			tail_q  <= tail_q + QPTR_W'(push_cnt);
			count_q <= count_q + QCNT_W'(push_cnt) - QCNT_W'(pop);
		end
	end

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != 2'd0) |-> (count_q <= ROOM_MAX) && (push_cnt != 2'd3))
		else $error("result push without room");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("result count above depth");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		pop && (push_cnt == 2'd0) |=> count_q == $past(count_q) - QCNT_W'(1))
		else $error("result count did not drop on pop");

endmodule

>>> hw/rtl/shell_expression_lexer_top.sv
// Expression lexer: one text byte per request, lexeme bytes out with one byte of lookahead.
// A request is registered in the input stage, and its results are written to the result
// queue when it has room. Throughput: one request per cycle while the queue has room and
// each gives at most one result; the two results of a two-byte operator, or of a held byte
// flushed at end, are absorbed by a four-entry result queue.
// Reset: arst_n clears the lexer mode, held byte, input stage and result queue.
module shell_expression_lexer_top (
	input  logic        clk,
	input  logic        arst_n,
	sel_text_if.sink    text,
	sel_token_if.source token
);
	import sel_pkg::*;

	item_t      item_s1;
	logic       valid_s1;
	logic       adv;
	logic       room;
	logic [1:0] res_cnt;
	res_t       res_lo;
	res_t       res_hi;

	assign adv        = valid_s1 && room;
	assign text.ready = !valid_s1 || adv;

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			item_s1.char_in     <= text.char_in;
			item_s1.char_valid  <= text.char_valid;
			item_s1.end_of_text <= text.end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	sel_lex_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.item    (item_s1),
		.res_cnt (res_cnt),
		.res_lo  (res_lo),
		.res_hi  (res_hi)
	);

	sel_res_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (adv ? res_cnt : 2'd0),
		.push_lo  (res_lo),
		.push_hi  (res_hi),
		.room     (room),
		.token    (token)
	);

endmodule
